// ===== src/video_crtc_timing_and_status_unit_assert.svh =====
// Assertion macros for the checker file.
`ifndef VIDEO_CRTC_TIMING_AND_STATUS_UNIT_ASSERT_SVH
`define VIDEO_CRTC_TIMING_AND_STATUS_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define VCTS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, disabled while reset is low
`define VCTS_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== src/vcts_pkg.sv =====
`default_nettype none
package vcts_pkg;

    // CRTC register file
    localparam int CRTC_REG_COUNT = 24;
    localparam int PTR_W          = 5;
    localparam int PTR_SPACE      = 2 ** PTR_W;

    // Stream widths
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 1;

    // Item kinds
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // I/O ports
    localparam logic [9:0] PORT_ATTR_IDX  = 10'h3C0;
    localparam logic [9:0] PORT_ATTR_DATA = 10'h3C1;
    localparam logic [9:0] PORT_MISC      = 10'h3C2;
    localparam logic [9:0] PORT_SEQ_IDX   = 10'h3C4;
    localparam logic [9:0] PORT_SEQ_DATA  = 10'h3C5;
    localparam logic [9:0] PORT_CRTC_IDX  = 10'h3D4;
    localparam logic [9:0] PORT_CRTC_DATA = 10'h3D5;
    localparam logic [9:0] PORT_STAT_MONO = 10'h3BA;
    localparam logic [9:0] PORT_STAT_COLR = 10'h3DA;

    // Register indexes
    localparam logic [4:0] ATTR_PLANE_EN  = 5'h12;
    localparam logic [3:0] SEQ_CLOCK_MODE = 4'h1;
    localparam logic [4:0] CR_H_TOTAL     = 5'd0;
    localparam logic [4:0] CR_H_DISP      = 5'd1;
    localparam logic [4:0] CR_V_TOTAL     = 5'd6;
    localparam logic [4:0] CR_OVERFLOW    = 5'd7;
    localparam logic [4:0] CR_MAX_SCAN    = 5'd9;
    localparam logic [4:0] CR_START_HI    = 5'd12;
    localparam logic [4:0] CR_START_LO    = 5'd13;
    localparam logic [4:0] CR_READ_HI     = 5'd17;
    localparam logic [4:0] CR_V_DISP_END  = 5'd18;
    localparam logic [4:0] CR_V_BLANK     = 5'd21;

    // Read constants
    localparam logic [3:0] SWITCHES    = 4'h7;
    localparam logic [7:0] STATUS_BASE = 8'hC0;
    localparam logic [7:0] RD_NONE     = 8'hFF;

    // Remainder unit
    localparam int DIV_W     = 9;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Controller to datapath
    typedef struct packed {
        logic latch;
        logic exec;
        logic line_fix;
        logic load_out;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic line_end;
        logic div_done;
        logic out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

// ===== src/vcts_mod_unit.sv =====
`default_nettype none
// Restoring remainder unit, one quotient bit per cycle
module vcts_mod_unit (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [vcts_pkg::DIV_W-1:0] dividend,
    input  wire logic [vcts_pkg::DIV_W-1:0] divisor,
    output logic                           done,
    output logic                           rem_zero
);
    import vcts_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     dvd_reg;
    logic [DIV_W-1:0]     div_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W:0]       trial;
    logic [DIV_W:0]       diff;
    logic                 fits;

    // One trial subtraction
    assign trial = {rem_reg, dvd_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = trial >= {1'b0, div_reg};

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DIV_W-2:0], 1'b0};
            rem_reg <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        end
    end

    assign done     = done_reg;
    assign rem_zero = (rem_reg == '0);

endmodule
`default_nettype wire

// ===== src/vcts_datapath.sv =====
`default_nettype none
// Register file, timing counters, read mux and result register
module vcts_datapath (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire vcts_pkg::dp_cmd_t              cmd,
    output vcts_pkg::dp_stat_t                  stat,
    input  wire logic [vcts_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic [vcts_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [vcts_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [vcts_pkg::M_TUSER_W-1:0]      m_tuser
);
    import vcts_pkg::*;

    // Latched item
    logic [1:0] op_reg;
    logic [9:0] port_reg;
    logic [7:0] wdata_reg;
    logic [3:0] pix_reg;

    // Block state
    logic [7:0]  file_reg [CRTC_REG_COUNT];
    logic [4:0]  crtc_ptr_reg;
    logic [4:0]  attr_ptr_reg;
    logic [7:0]  plane_en_reg;
    logic [7:0]  misc_reg;
    logic [3:0]  seq_ptr_reg;
    logic [3:0]  clock_mode_reg;
    logic [11:0] char_reg;
    logic [8:0]  scan_reg;
    logic [16:0] row_reg;
    logic [7:0]  frame_reg;
    logic        vblank_reg;
    logic        half_reg;

    // Per-item results
    logic [7:0]  rd_reg;
    logic        done_reg;
    logic [8:0]  num_reg;
    logic [11:0] width_reg;

    // Output register
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic                 out_user_reg;

    // Full pointer space; absent registers read as zero
    logic [7:0] creg_w [PTR_SPACE];
    for (genvar k = 0; k < PTR_SPACE; k++) begin : g_creg
        if (k < CRTC_REG_COUNT) begin : g_have
            assign creg_w[k] = file_reg[k];
        end else begin : g_none
            assign creg_w[k] = '0;
        end
    end

    // Timing values from the register file
    logic [8:0]  h_disp_p1;
    logic [11:0] h_disp;
    logic [11:0] line_clocks;
    logic [9:0]  v_disp;
    logic [8:0]  vbs;
    logic [8:0]  total_lines;
    logic [8:0]  char_height;
    logic [16:0] row_step;
    logic [16:0] row_reload;

    assign h_disp_p1   = {1'b0, creg_w[CR_H_DISP]} + 9'd1;
    assign h_disp      = {h_disp_p1, 3'b000};
    assign line_clocks = {({1'b0, creg_w[CR_H_TOTAL]} + 9'd2), 3'b000};
    assign v_disp      = {1'b0, creg_w[CR_OVERFLOW][1], creg_w[CR_V_DISP_END]} + 10'd1;
    assign vbs         = {creg_w[CR_OVERFLOW][3], creg_w[CR_V_BLANK]};
    assign total_lines = {creg_w[CR_OVERFLOW][0], creg_w[CR_V_TOTAL]};
    assign char_height = {1'b0, creg_w[CR_MAX_SCAN]} + 9'd1;
    assign row_step    = {7'd0, h_disp_p1, 1'b0};
    assign row_reload  = {creg_w[CR_START_HI], creg_w[CR_START_LO], 1'b0};

    // Tick decode
    logic        counted;
    logic [11:0] char_inc;
    logic [8:0]  scan_inc;
    logic        line_end;

    assign counted  = clock_mode_reg[3] ? half_reg : 1'b1;
    assign char_inc = char_reg + 12'd1;
    assign scan_inc = scan_reg + 9'd1;
    assign line_end = (op_reg == OP_TICK) && counted && (char_inc >= line_clocks);

    // Read mux
    logic       disp_en;
    logic [1:0] diag;
    logic [7:0] rd_w;

    assign disp_en = (char_reg < h_disp) && ({1'b0, scan_reg} < v_disp);

    always_comb begin
        case (plane_en_reg[5:4])
            2'd0:    diag = {pix_reg[2], pix_reg[0]};
            2'd1:    diag = {pix_reg[3], pix_reg[1]};
            2'd2:    diag = {pix_reg[3], pix_reg[3]};
            default: diag = 2'b00;
        endcase
    end

    always_comb begin
        rd_w = RD_NONE;
        if (port_reg == PORT_MISC) begin
            rd_w = {3'b000, SWITCHES[2'd3 - misc_reg[3:2]], 4'b0000};
        end else if (port_reg == PORT_CRTC_DATA) begin
            if (crtc_ptr_reg >= CR_START_HI && crtc_ptr_reg <= CR_READ_HI
                && {27'd0, crtc_ptr_reg} < CRTC_REG_COUNT) begin
                rd_w = creg_w[crtc_ptr_reg];
            end
        end else if (port_reg == PORT_STAT_MONO || port_reg == PORT_STAT_COLR) begin
            rd_w = STATUS_BASE | {2'b00, diag, vblank_reg, 2'b00, ~disp_en};
        end
    end

    // Row boundary test on the new scanline
    logic mod_done;
    logic rem_zero;

    vcts_mod_unit u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.exec && line_end),
        .dividend (scan_inc),
        .divisor  (char_height),
        .done     (mod_done),
        .rem_zero (rem_zero)
    );

    // Item latch and per-item results
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            op_reg    <= s_tuser;
            port_reg  <= s_tdata[9:0];
            wdata_reg <= s_tdata[17:10];
            pix_reg   <= s_tdata[21:18];
        end
        if (cmd.exec) begin
            rd_reg    <= (op_reg == OP_READ) ? rd_w : RD_NONE;
            done_reg  <= 1'b0;
            num_reg   <= '0;
            width_reg <= '0;
            if (line_end && ({1'b0, scan_reg} < v_disp)) begin
                done_reg  <= 1'b1;
                num_reg   <= scan_reg;
                width_reg <= h_disp;
            end
        end
    end

    // Block state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < CRTC_REG_COUNT; k++) begin
                file_reg[k] <= '0;
            end
            crtc_ptr_reg   <= '0;
            attr_ptr_reg   <= '0;
            plane_en_reg   <= '0;
            misc_reg       <= '0;
            seq_ptr_reg    <= '0;
            clock_mode_reg <= '0;
            char_reg       <= '0;
            scan_reg       <= '0;
            row_reg        <= '0;
            frame_reg      <= '0;
            vblank_reg     <= 1'b0;
            half_reg       <= 1'b0;
        end else if (cmd.exec) begin
            case (op_reg)
                OP_TICK: begin
                    half_reg <= clock_mode_reg[3] ? ~half_reg : 1'b0;
                    if (counted) begin
                        if (line_end) begin
                            char_reg <= '0;
                            scan_reg <= scan_inc;
                        end else begin
                            char_reg <= char_inc;
                        end
                    end
                end
                OP_WRITE: begin
                    case (port_reg)
                        PORT_ATTR_IDX: attr_ptr_reg <= wdata_reg[4:0];
                        PORT_ATTR_DATA: begin
                            if (attr_ptr_reg == ATTR_PLANE_EN) plane_en_reg <= wdata_reg;
                        end
                        PORT_MISC:    misc_reg <= wdata_reg;
                        PORT_SEQ_IDX: seq_ptr_reg <= wdata_reg[3:0];
                        PORT_SEQ_DATA: begin
                            if (seq_ptr_reg == SEQ_CLOCK_MODE) clock_mode_reg <= wdata_reg[3:0];
                        end
                        PORT_CRTC_IDX: crtc_ptr_reg <= wdata_reg[4:0];
                        PORT_CRTC_DATA: begin
                            for (int k = 0; k < CRTC_REG_COUNT; k++) begin
                                if (crtc_ptr_reg == PTR_W'(k)) file_reg[k] <= wdata_reg;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end else if (cmd.line_fix) begin
            // Frame wrap, row step, vblank entry
            if (scan_reg >= total_lines) begin
                scan_reg   <= '0;
                frame_reg  <= frame_reg + 8'd1;
                row_reg    <= row_reload;
                vblank_reg <= 1'b0;
            end else begin
                if (rem_zero) row_reg <= row_reg + row_step;
                if (scan_reg >= vbs) vblank_reg <= 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_data_reg <= {1'b0, (scan_reg >= vbs), frame_reg, row_reg,
                             width_reg, num_reg, rd_reg};
            out_user_reg <= done_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    assign stat.line_end = line_end;
    assign stat.div_done = mod_done;
    assign stat.out_free = !out_valid_reg || m_tready;

endmodule
`default_nettype wire

// ===== src/vcts_ctrl.sv =====
`default_nettype none
// Item sequencer
module vcts_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    output vcts_pkg::dp_cmd_t       cmd,
    input  wire vcts_pkg::dp_stat_t stat
);
    import vcts_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_EXEC = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_LINE = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_EXEC;
            ST_EXEC: state_next = stat.line_end ? ST_DIV : ST_OUT;
            ST_DIV:  if (stat.div_done) state_next = ST_LINE;
            ST_LINE: state_next = ST_OUT;
            ST_OUT:  if (stat.out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Commands
    assign s_tready     = (state_reg == ST_IDLE);
    assign cmd.latch    = (state_reg == ST_IDLE) && s_tvalid;
    assign cmd.exec     = (state_reg == ST_EXEC);
    assign cmd.line_fix = (state_reg == ST_LINE);
    assign cmd.load_out = (state_reg == ST_OUT) && stat.out_free;

endmodule
`default_nettype wire

// ===== src/video_crtc_timing_and_status_unit.sv =====
`default_nettype none
// Channel  Dir  Handshake            Content
// s_       in   s_tvalid/s_tready    tuser: operation; tdata: port, write byte, last pixel
// m_       out  m_tvalid/m_tready    tuser: line_done; tdata: read byte, line info, status
//
// Most items pass through accept, execute and load of the result register.
// A tick that ends a scanline also waits after execute while the remainder unit
// runs 9 bit steps and flags done, then does the row, frame and vblank update.
// Synchronous active-low reset clears the CRTC file, counters, pointers and FSM state.
// A result waits in the output register while the next item is accepted;
// a stalled m_ side holds the block only when a new result is ready.
module video_crtc_timing_and_status_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [9:0] port_address, [17:10] write_data, [21:18] last_pixel
    input  wire logic [vcts_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] operation
    input  wire logic [vcts_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [7:0] read_data, [16:8] line_number, [28:17] line_width,
    // [45:29] row_address, [53:46] frame_number, [54] in_vblank
    output logic [vcts_pkg::M_TDATA_W-1:0]      m_tdata,
    // [0] line_done
    output logic [vcts_pkg::M_TUSER_W-1:0]      m_tuser
);
    import vcts_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    vcts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    vcts_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

// ===== src/vcts_checker.sv =====
`default_nettype none
`include "video_crtc_timing_and_status_unit_assert.svh"
// Port-level checks on the top level
module vcts_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [vcts_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [vcts_pkg::M_TUSER_W-1:0] m_tuser
);
    import vcts_pkg::*;

    // Stalled result holds
    `VCTS_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // One item at a time: no accept right after an accept
    `VCTS_ASSERT_NXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // Line info is zero unless a line finished
    `VCTS_ASSERT_IMP(a_line_zero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata[28:8] == 21'd0)

    // A finished line comes from a tick, never from a read
    `VCTS_ASSERT_IMP(a_line_no_rd, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata[7:0] == RD_NONE)

endmodule

bind video_crtc_timing_and_status_unit vcts_checker u_vcts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

// ===== sim/video_crtc_timing_and_status_unit_test.sv =====
`timescale 1ns / 1ps
module video_crtc_timing_and_status_unit_test;
    import vcts_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 800;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 32;

    // Kind code with no function in the block
    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam logic [9:0] PORT_UNMAPPED = 10'h000;

    // CRTC indexes that drive the timing
    localparam logic [4:0] TIMING_REGS [9] = '{
        CR_H_TOTAL, CR_H_DISP, CR_V_TOTAL, CR_OVERFLOW, CR_MAX_SCAN,
        CR_START_HI, CR_START_LO, CR_V_DISP_END, CR_V_BLANK
    };

    typedef enum int {
        PH_NONE, PH_SEND, PH_RECV, PH_BOTH, PH_BURST
    } idle_phase_e;

    typedef struct {
        logic [7:0]  read_data;
        logic        line_done;
        logic [8:0]  line_number;
        logic [11:0] line_width;
        logic [16:0] row_address;
        logic [7:0]  frame_number;
        logic        in_vblank;
    } crtc_result_t;

    typedef struct {
        logic [1:0] op;
        logic [9:0] port;
        logic [7:0] wdata;
        logic [3:0] pix;
        bit         fixed;
        logic [7:0] rd;
    } directed_row_t;

    // Directed items; rd is the typed read byte where fixed is set
    directed_row_t directed_rows [26] = '{
        '{OP_READ,   PORT_STAT_COLR, 8'h00, 4'h0, 1'b1, 8'hC0},
        '{OP_READ,   PORT_CRTC_DATA, 8'h00, 4'h0, 1'b1, 8'hFF},
        '{OP_READ,   PORT_MISC,      8'h00, 4'h0, 1'b1, 8'h00},
        '{OP_UNUSED, 10'h3FF,        8'hFF, 4'hF, 1'b1, 8'hFF},
        '{OP_READ,   PORT_UNMAPPED,  8'h00, 4'hF, 1'b1, 8'hFF},
        '{OP_WRITE,  PORT_MISC,      8'h0C, 4'h0, 1'b0, 8'h00},
        '{OP_READ,   PORT_MISC,      8'h00, 4'h0, 1'b1, 8'h10},
        '{OP_WRITE,  PORT_ATTR_IDX,  8'h12, 4'h0, 1'b0, 8'h00},
        '{OP_WRITE,  PORT_ATTR_DATA, 8'h20, 4'h0, 1'b0, 8'h00},
        '{OP_READ,   PORT_STAT_MONO, 8'h00, 4'h8, 1'b1, 8'hF0},
        '{OP_WRITE,  PORT_CRTC_IDX,  8'h1F, 4'h0, 1'b0, 8'h00},
        '{OP_WRITE,  PORT_CRTC_DATA, 8'hAA, 4'h0, 1'b0, 8'h00},
        '{OP_READ,   PORT_CRTC_DATA, 8'h00, 4'h0, 1'b1, 8'hFF},
        '{OP_WRITE,  PORT_CRTC_IDX,  8'h0C, 4'h0, 1'b0, 8'h00},
        '{OP_WRITE,  PORT_CRTC_DATA, 8'hFF, 4'h0, 1'b0, 8'h00},
        '{OP_WRITE,  PORT_CRTC_IDX,  8'h0D, 4'h0, 1'b0, 8'h00},
        '{OP_WRITE,  PORT_CRTC_DATA, 8'hFF, 4'h0, 1'b0, 8'h00},
        '{OP_READ,   PORT_CRTC_DATA, 8'h00, 4'h5, 1'b0, 8'h00},
        '{OP_WRITE,  PORT_SEQ_IDX,   8'h01, 4'h0, 1'b0, 8'h00},
        '{OP_WRITE,  PORT_SEQ_DATA,  8'hFF, 4'h0, 1'b0, 8'h00},
        '{OP_TICK,   PORT_UNMAPPED,  8'h00, 4'h0, 1'b0, 8'h00},
        '{OP_TICK,   PORT_UNMAPPED,  8'h00, 4'h0, 1'b0, 8'h00},
        '{OP_TICK,   PORT_UNMAPPED,  8'h00, 4'h0, 1'b0, 8'h00},
        '{OP_WRITE,  PORT_SEQ_DATA,  8'h00, 4'h0, 1'b0, 8'h00},
        '{OP_TICK,   PORT_UNMAPPED,  8'h00, 4'h0, 1'b0, 8'h00},
        '{OP_WRITE,  PORT_CRTC_IDX,  8'h00, 4'h0, 1'b0, 8'h00}
    };

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // [9:0] port_address, [17:10] write_data, [21:18] last_pixel
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    // [1:0] operation
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [7:0] read_data, [16:8] line_number, [28:17] line_width,
    // [45:29] row_address, [53:46] frame_number, [54] in_vblank
    logic [M_TDATA_W-1:0] m_tdata;
    // [0] line_done
    logic [M_TUSER_W-1:0] m_tuser;

    crtc_result_t expected_results [$];
    crtc_result_t head_res;
    int           fail_count    = 0;
    int           items_sent    = 0;
    int           cycle_count   = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           hold_requests = 0;
    int           hold_served   = 0;
    int           hold_left     = 0;

    // Shadow of the block's registers and counters
    logic [7:0]  crtc_regs [CRTC_REG_COUNT];
    logic [4:0]  crtc_index     = '0;
    logic [4:0]  attr_index     = '0;
    logic [7:0]  plane_enable   = '0;
    logic [7:0]  misc_output    = '0;
    logic [3:0]  seq_index      = '0;
    logic [3:0]  clock_mode     = '0;
    logic [11:0] char_clock     = '0;
    logic [8:0]  scanline       = '0;
    logic [16:0] row_start_addr = '0;
    logic [7:0]  frame_ctr      = '0;
    logic        vblank_seen    = 1'b0;
    logic        half_tick      = 1'b0;

    video_crtc_timing_and_status_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // Absent registers read as zero inside the timing
    function automatic int unsigned crtc_reg(input int unsigned idx);
        return (idx < CRTC_REG_COUNT) ? int'(crtc_regs[idx]) : 0;
    endfunction

    // Advance the shadow by one item and return what the block should report
    function automatic crtc_result_t predict_item(input logic [1:0] op,
                                                  input logic [9:0] port,
                                                  input logic [7:0] wdata,
                                                  input logic [3:0] pix);
        crtc_result_t res;
        int unsigned  line_clocks, char_height, total_lines;
        int unsigned  h_disp, v_disp, vb_start, sel;
        logic         counted, de;
        logic [1:0]   diag;
        res.read_data    = RD_NONE;
        res.line_done    = 1'b0;
        res.line_number  = '0;
        res.line_width   = '0;
        h_disp   = (crtc_reg(CR_H_DISP) + 1) * 8;
        v_disp   = (crtc_reg(CR_V_DISP_END) | (((crtc_reg(CR_OVERFLOW) >> 1) & 1) << 8)) + 1;
        vb_start = crtc_reg(CR_V_BLANK) | (((crtc_reg(CR_OVERFLOW) >> 3) & 1) << 8);
        case (op)
            OP_TICK: begin
                // half clock: only every second tick counts
                if (clock_mode[3]) begin
                    counted   = half_tick;
                    half_tick = ~half_tick;
                end else begin
                    counted   = 1'b1;
                    half_tick = 1'b0;
                end
                if (counted) begin
                    line_clocks = (crtc_reg(CR_H_TOTAL) + 2) * 8;
                    char_height = crtc_reg(CR_MAX_SCAN) + 1;
                    total_lines = crtc_reg(CR_V_TOTAL) | ((crtc_reg(CR_OVERFLOW) & 1) << 8);
                    char_clock  = char_clock + 12'd1;
                    if (char_clock >= line_clocks) begin
                        if (scanline < v_disp) begin
                            res.line_done   = 1'b1;
                            res.line_number = scanline;
                            res.line_width  = 12'(h_disp);
                        end
                        char_clock = '0;
                        scanline   = scanline + 9'd1;
                        if ((scanline % char_height) == 0)
                            row_start_addr = 17'(row_start_addr + (crtc_reg(CR_H_DISP) + 1) * 2);
                        // frame restart at the vertical total
                        if (scanline >= total_lines) begin
                            scanline       = '0;
                            frame_ctr      = frame_ctr + 8'd1;
                            row_start_addr = 17'(((crtc_reg(CR_START_HI) << 8)
                                                  | crtc_reg(CR_START_LO)) * 2);
                            vblank_seen    = 1'b0;
                        end else if (scanline >= vb_start) begin
                            vblank_seen = 1'b1;
                        end
                    end
                end
            end
            OP_READ: begin
                case (port)
                    PORT_MISC: begin
                        sel = misc_output[3:2];
                        res.read_data = 8'(((int'(SWITCHES) >> (3 - sel)) & 1) << 4);
                    end
                    PORT_CRTC_DATA: begin
                        if (crtc_index >= CR_START_HI && crtc_index <= CR_READ_HI
                            && crtc_index < CRTC_REG_COUNT)
                            res.read_data = crtc_regs[crtc_index];
                    end
                    PORT_STAT_MONO, PORT_STAT_COLR: begin
                        de = (char_clock < h_disp) && (scanline < v_disp);
                        // diagnostic mux picks two bits of the last pixel
                        case (plane_enable[5:4])
                            2'd0:    diag = {pix[2], pix[0]};
                            2'd1:    diag = {pix[3], pix[1]};
                            2'd2:    diag = {pix[3], pix[3]};
                            default: diag = 2'b00;
                        endcase
                        res.read_data = STATUS_BASE | {2'b00, diag, vblank_seen, 2'b00, ~de};
                    end
                    default: res.read_data = RD_NONE;
                endcase
            end
            OP_WRITE: begin
                case (port)
                    PORT_ATTR_IDX:  attr_index = wdata[4:0];
                    PORT_ATTR_DATA: if (attr_index == ATTR_PLANE_EN) plane_enable = wdata;
                    PORT_MISC:      misc_output = wdata;
                    PORT_SEQ_IDX:   seq_index = wdata[3:0];
                    PORT_SEQ_DATA:  if (seq_index == SEQ_CLOCK_MODE) clock_mode = wdata[3:0];
                    PORT_CRTC_IDX:  crtc_index = wdata[4:0];
                    PORT_CRTC_DATA: if (crtc_index < CRTC_REG_COUNT) crtc_regs[crtc_index] = wdata;
                    default: ;
                endcase
            end
            default: ;
        endcase
        // a write may have moved the blank start
        vb_start = crtc_reg(CR_V_BLANK) | (((crtc_reg(CR_OVERFLOW) >> 3) & 1) << 8);
        res.row_address  = row_start_addr;
        res.frame_number = frame_ctr;
        res.in_vblank    = (scanline >= vb_start);
        return res;
    endfunction

    // Offer one item, wait for its handshake, then queue what it should produce
    task automatic offer_item(input logic [1:0] op, input logic [9:0] port,
                              input logic [7:0] wdata, input logic [3:0] pix,
                              input bit fixed, input logic [7:0] fixed_rd);
        crtc_result_t res;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, pix, wdata, port};
        do @(posedge aclk); while (!s_tready);
        res = predict_item(op, port, wdata, pix);
        if (fixed)
            res.read_data = fixed_rd;
        expected_results.push_back(res);
        items_sent++;
    endtask

    // Result side: compare, then pick next ready level
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result item: tdata %h tuser %h", m_tdata, m_tuser);
                    fail_count++;
                end else begin
                    head_res = expected_results.pop_front();
                    if (m_tdata[7:0] !== head_res.read_data) begin
                        $error("read_data: expected %0h, got %0h",
                               head_res.read_data, m_tdata[7:0]);
                        fail_count++;
                    end
                    if (m_tuser[0] !== head_res.line_done) begin
                        $error("line_done: expected %0d, got %0d",
                               head_res.line_done, m_tuser[0]);
                        fail_count++;
                    end
                    if (m_tdata[16:8] !== head_res.line_number) begin
                        $error("line_number: expected %0d, got %0d",
                               head_res.line_number, m_tdata[16:8]);
                        fail_count++;
                    end
                    if (m_tdata[28:17] !== head_res.line_width) begin
                        $error("line_width: expected %0d, got %0d",
                               head_res.line_width, m_tdata[28:17]);
                        fail_count++;
                    end
                    if (m_tdata[45:29] !== head_res.row_address) begin
                        $error("row_address: expected %0h, got %0h",
                               head_res.row_address, m_tdata[45:29]);
                        fail_count++;
                    end
                    if (m_tdata[53:46] !== head_res.frame_number) begin
                        $error("frame_number: expected %0d, got %0d",
                               head_res.frame_number, m_tdata[53:46]);
                        fail_count++;
                    end
                    if (m_tdata[54] !== head_res.in_vblank) begin
                        $error("in_vblank: expected %0d, got %0d",
                               head_res.in_vblank, m_tdata[54]);
                        fail_count++;
                    end
                end
            end
            // long hold-off on request, else random stalls
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int          phase_end;
        int          pick;
        logic [4:0]  reg_idx;
        logic [7:0]  reg_val;
        logic [9:0]  rd_port;
        idle_phase_e phase;
        foreach (crtc_regs[i])
            crtc_regs[i] = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed items
        foreach (directed_rows[i])
            offer_item(directed_rows[i].op, directed_rows[i].port, directed_rows[i].wdata,
                       directed_rows[i].pix, directed_rows[i].fixed, directed_rows[i].rd);

        // Random items, one idle pattern per phase
        for (int p = 0; p <= int'(PH_BURST); p++) begin
            phase = idle_phase_e'(p);
            case (phase)
                PH_NONE:  begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                PH_SEND:  begin send_idle_pct = 74; recv_stall_pct = 0;  end
                PH_RECV:  begin send_idle_pct = 0;  recv_stall_pct = 74; end
                PH_BOTH:  begin send_idle_pct = 7;  recv_stall_pct = 7;  end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    hold_requests++;
                end
            endcase
            phase_end = items_sent + RANDOM_ITEMS / 5;
            while (items_sent < phase_end) begin
                pick = $urandom_range(99);
                if (pick < 58) begin
                    // tick; the unused fields carry noise
                    offer_item(OP_TICK, 10'($urandom), 8'($urandom), 4'($urandom),
                               1'b0, RD_NONE);
                end else if (pick < 74) begin
                    // CRTC update: index then data, values kept mostly short
                    reg_idx = ($urandom_range(9) == 0) ? 5'($urandom)
                                                       : TIMING_REGS[$urandom_range(8)];
                    case (reg_idx)
                        CR_H_TOTAL:
                            reg_val = ($urandom_range(99) < 3) ? 8'($urandom)
                                                               : 8'($urandom_range(3));
                        CR_H_DISP:
                            reg_val = ($urandom_range(99) < 10) ? 8'($urandom)
                                                                : 8'($urandom_range(7));
                        CR_V_TOTAL, CR_V_DISP_END, CR_V_BLANK:
                            reg_val = ($urandom_range(99) < 5) ? 8'($urandom)
                                                               : 8'($urandom_range(12));
                        CR_OVERFLOW:
                            reg_val = ($urandom_range(99) < 20) ? 8'($urandom) : 8'h00;
                        CR_MAX_SCAN:
                            reg_val = ($urandom_range(99) < 5) ? 8'($urandom)
                                                               : 8'($urandom_range(3));
                        default: reg_val = 8'($urandom);
                    endcase
                    offer_item(OP_WRITE, PORT_CRTC_IDX, {3'($urandom), reg_idx},
                               4'($urandom), 1'b0, RD_NONE);
                    offer_item(OP_WRITE, PORT_CRTC_DATA, reg_val, 4'($urandom), 1'b0, RD_NONE);
                end else if (pick < 84) begin
                    // reads of status, misc, CRTC data or anything else
                    case ($urandom_range(4))
                        0: rd_port = PORT_MISC;
                        1: begin
                            offer_item(OP_WRITE, PORT_CRTC_IDX, 8'($urandom_range(10, 19)),
                                       4'($urandom), 1'b0, RD_NONE);
                            rd_port = PORT_CRTC_DATA;
                        end
                        2: rd_port = PORT_STAT_MONO;
                        3: rd_port = PORT_STAT_COLR;
                        default: rd_port = 10'($urandom);
                    endcase
                    offer_item(OP_READ, rd_port, 8'($urandom), 4'($urandom), 1'b0, RD_NONE);
                end else if (pick < 94) begin
                    // attribute, sequencer and misc registers
                    case ($urandom_range(2))
                        0: begin
                            reg_val = ($urandom_range(9) < 7) ? {3'($urandom), ATTR_PLANE_EN}
                                                              : 8'($urandom);
                            offer_item(OP_WRITE, PORT_ATTR_IDX, reg_val, 4'($urandom),
                                       1'b0, RD_NONE);
                            offer_item(OP_WRITE, PORT_ATTR_DATA, 8'($urandom), 4'($urandom),
                                       1'b0, RD_NONE);
                        end
                        1: begin
                            reg_val = ($urandom_range(9) < 7) ? {4'($urandom), SEQ_CLOCK_MODE}
                                                              : 8'($urandom);
                            offer_item(OP_WRITE, PORT_SEQ_IDX, reg_val, 4'($urandom),
                                       1'b0, RD_NONE);
                            offer_item(OP_WRITE, PORT_SEQ_DATA, 8'($urandom), 4'($urandom),
                                       1'b0, RD_NONE);
                        end
                        default:
                            offer_item(OP_WRITE, PORT_MISC, 8'($urandom), 4'($urandom),
                                       1'b0, RD_NONE);
                    endcase
                end else begin
                    // noise: any kind, any port
                    offer_item(2'($urandom), 10'($urandom), 8'($urandom), 4'($urandom),
                               1'b0, RD_NONE);
                end
            end
        end
        s_tvalid <= 1'b0;

        // Drain, then let a few more cycles pass for stray results
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/vcts_pkg.sv
src/vcts_mod_unit.sv
src/vcts_datapath.sv
src/vcts_ctrl.sv
src/video_crtc_timing_and_status_unit.sv
src/vcts_checker.sv
sim/video_crtc_timing_and_status_unit_test.sv
